// File: rtl/belt_block_encrypt_unit_macros.svh
// ----------------------------------------------------------------------------
// belt_block_encrypt_unit_macros
// Assertion macros for the block cipher unit.
// ----------------------------------------------------------------------------
`ifndef BELT_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define BELT_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BEU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BEU_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BEU_ASSERT(lbl, clk, rst_n, prop, msg)
`define BEU_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/belt_pkg.sv
// ----------------------------------------------------------------------------
// belt_pkg
// Types, constants and the S-box/G functions of the block cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package belt_pkg;

  localparam int unsigned NumRounds   = 8;
  localparam int unsigned NumKeyWords = 8;
  localparam int unsigned NumCfgRegs  = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;
  // Stages per round: three steps of dependent G evaluations.
  localparam int unsigned StagesPerRound = 3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] plain_word_a;
    logic [31:0] plain_word_b;
    logic [31:0] plain_word_c;
    logic [31:0] plain_word_d;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cipher_word_0;
    logic [31:0] cipher_word_1;
    logic [31:0] cipher_word_2;
    logic [31:0] cipher_word_3;
  } out_item_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } state_t;

  function automatic logic [7:0] hbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'h00: r=8'hB1; 8'h01: r=8'h94; 8'h02: r=8'hBA; 8'h03: r=8'hC8;
      8'h04: r=8'h0A; 8'h05: r=8'h08; 8'h06: r=8'hF5; 8'h07: r=8'h3B;
      8'h08: r=8'h36; 8'h09: r=8'h6D; 8'h0A: r=8'h00; 8'h0B: r=8'h8E;
      8'h0C: r=8'h58; 8'h0D: r=8'h4A; 8'h0E: r=8'h5D; 8'h0F: r=8'hE4;
      8'h10: r=8'h85; 8'h11: r=8'h04; 8'h12: r=8'hFA; 8'h13: r=8'h9D;
      8'h14: r=8'h1B; 8'h15: r=8'hB6; 8'h16: r=8'hC7; 8'h17: r=8'hAC;
      8'h18: r=8'h25; 8'h19: r=8'h2E; 8'h1A: r=8'h72; 8'h1B: r=8'hC2;
      8'h1C: r=8'h02; 8'h1D: r=8'hFD; 8'h1E: r=8'hCE; 8'h1F: r=8'h0D;
      8'h20: r=8'h5B; 8'h21: r=8'hE3; 8'h22: r=8'hD6; 8'h23: r=8'h12;
      8'h24: r=8'h17; 8'h25: r=8'hB9; 8'h26: r=8'h61; 8'h27: r=8'h81;
      8'h28: r=8'hFE; 8'h29: r=8'h67; 8'h2A: r=8'h86; 8'h2B: r=8'hAD;
      8'h2C: r=8'h71; 8'h2D: r=8'h6B; 8'h2E: r=8'h89; 8'h2F: r=8'h0B;
      8'h30: r=8'h5C; 8'h31: r=8'hB0; 8'h32: r=8'hC0; 8'h33: r=8'hFF;
      8'h34: r=8'h33; 8'h35: r=8'hC3; 8'h36: r=8'h56; 8'h37: r=8'hB8;
      8'h38: r=8'h35; 8'h39: r=8'hC4; 8'h3A: r=8'h05; 8'h3B: r=8'hAE;
      8'h3C: r=8'hD8; 8'h3D: r=8'hE0; 8'h3E: r=8'h7F; 8'h3F: r=8'h99;
      8'h40: r=8'hE1; 8'h41: r=8'h2B; 8'h42: r=8'hDC; 8'h43: r=8'h1A;
      8'h44: r=8'hE2; 8'h45: r=8'h82; 8'h46: r=8'h57; 8'h47: r=8'hEC;
      8'h48: r=8'h70; 8'h49: r=8'h3F; 8'h4A: r=8'hCC; 8'h4B: r=8'hF0;
      8'h4C: r=8'h95; 8'h4D: r=8'hEE; 8'h4E: r=8'h8D; 8'h4F: r=8'hF1;
      8'h50: r=8'hC1; 8'h51: r=8'hAB; 8'h52: r=8'h76; 8'h53: r=8'h38;
      8'h54: r=8'h9F; 8'h55: r=8'hE6; 8'h56: r=8'h78; 8'h57: r=8'hCA;
      8'h58: r=8'hF7; 8'h59: r=8'hC6; 8'h5A: r=8'hF8; 8'h5B: r=8'h60;
      8'h5C: r=8'hD5; 8'h5D: r=8'hBB; 8'h5E: r=8'h9C; 8'h5F: r=8'h4F;
      8'h60: r=8'hF3; 8'h61: r=8'h3C; 8'h62: r=8'h65; 8'h63: r=8'h7B;
      8'h64: r=8'h63; 8'h65: r=8'h7C; 8'h66: r=8'h30; 8'h67: r=8'h6A;
      8'h68: r=8'hDD; 8'h69: r=8'h4E; 8'h6A: r=8'hA7; 8'h6B: r=8'h79;
      8'h6C: r=8'h9E; 8'h6D: r=8'hB2; 8'h6E: r=8'h3D; 8'h6F: r=8'h31;
      8'h70: r=8'h3E; 8'h71: r=8'h98; 8'h72: r=8'hB5; 8'h73: r=8'h6E;
      8'h74: r=8'h27; 8'h75: r=8'hD3; 8'h76: r=8'hBC; 8'h77: r=8'hCF;
      8'h78: r=8'h59; 8'h79: r=8'h1E; 8'h7A: r=8'h18; 8'h7B: r=8'h1F;
      8'h7C: r=8'h4C; 8'h7D: r=8'h5A; 8'h7E: r=8'hB7; 8'h7F: r=8'h93;
      8'h80: r=8'hE9; 8'h81: r=8'hDE; 8'h82: r=8'hE7; 8'h83: r=8'h2C;
      8'h84: r=8'h8F; 8'h85: r=8'h0C; 8'h86: r=8'h0F; 8'h87: r=8'hA6;
      8'h88: r=8'h2D; 8'h89: r=8'hDB; 8'h8A: r=8'h49; 8'h8B: r=8'hF4;
      8'h8C: r=8'h6F; 8'h8D: r=8'h73; 8'h8E: r=8'h96; 8'h8F: r=8'h47;
      8'h90: r=8'h06; 8'h91: r=8'h07; 8'h92: r=8'h53; 8'h93: r=8'h16;
      8'h94: r=8'hED; 8'h95: r=8'h24; 8'h96: r=8'h7A; 8'h97: r=8'h37;
      8'h98: r=8'h39; 8'h99: r=8'hCB; 8'h9A: r=8'hA3; 8'h9B: r=8'h83;
      8'h9C: r=8'h03; 8'h9D: r=8'hA9; 8'h9E: r=8'h8B; 8'h9F: r=8'hF6;
      8'hA0: r=8'h92; 8'hA1: r=8'hBD; 8'hA2: r=8'h9B; 8'hA3: r=8'h1C;
      8'hA4: r=8'hE5; 8'hA5: r=8'hD1; 8'hA6: r=8'h41; 8'hA7: r=8'h01;
      8'hA8: r=8'h54; 8'hA9: r=8'h45; 8'hAA: r=8'hFB; 8'hAB: r=8'hC9;
      8'hAC: r=8'h5E; 8'hAD: r=8'h4D; 8'hAE: r=8'h0E; 8'hAF: r=8'hF2;
      8'hB0: r=8'h68; 8'hB1: r=8'h20; 8'hB2: r=8'h80; 8'hB3: r=8'hAA;
      8'hB4: r=8'h22; 8'hB5: r=8'h7D; 8'hB6: r=8'h64; 8'hB7: r=8'h2F;
      8'hB8: r=8'h26; 8'hB9: r=8'h87; 8'hBA: r=8'hF9; 8'hBB: r=8'h34;
      8'hBC: r=8'h90; 8'hBD: r=8'h40; 8'hBE: r=8'h55; 8'hBF: r=8'h11;
      8'hC0: r=8'hBE; 8'hC1: r=8'h32; 8'hC2: r=8'h97; 8'hC3: r=8'h13;
      8'hC4: r=8'h43; 8'hC5: r=8'hFC; 8'hC6: r=8'h9A; 8'hC7: r=8'h48;
      8'hC8: r=8'hA0; 8'hC9: r=8'h2A; 8'hCA: r=8'h88; 8'hCB: r=8'h5F;
      8'hCC: r=8'h19; 8'hCD: r=8'h4B; 8'hCE: r=8'h09; 8'hCF: r=8'hA1;
      8'hD0: r=8'h7E; 8'hD1: r=8'hCD; 8'hD2: r=8'hA4; 8'hD3: r=8'hD0;
      8'hD4: r=8'h15; 8'hD5: r=8'h44; 8'hD6: r=8'hAF; 8'hD7: r=8'h8C;
      8'hD8: r=8'hA5; 8'hD9: r=8'h84; 8'hDA: r=8'h50; 8'hDB: r=8'hBF;
      8'hDC: r=8'h66; 8'hDD: r=8'hD2; 8'hDE: r=8'hE8; 8'hDF: r=8'h8A;
      8'hE0: r=8'hA2; 8'hE1: r=8'hD7; 8'hE2: r=8'h46; 8'hE3: r=8'h52;
      8'hE4: r=8'h42; 8'hE5: r=8'hA8; 8'hE6: r=8'hDF; 8'hE7: r=8'hB3;
      8'hE8: r=8'h69; 8'hE9: r=8'h74; 8'hEA: r=8'hC5; 8'hEB: r=8'h51;
      8'hEC: r=8'hEB; 8'hED: r=8'h23; 8'hEE: r=8'h29; 8'hEF: r=8'h21;
      8'hF0: r=8'hD4; 8'hF1: r=8'hEF; 8'hF2: r=8'hD9; 8'hF3: r=8'hB4;
      8'hF4: r=8'h3A; 8'hF5: r=8'h62; 8'hF6: r=8'h28; 8'hF7: r=8'h75;
      8'hF8: r=8'h91; 8'hF9: r=8'h14; 8'hFA: r=8'h10; 8'hFB: r=8'hEA;
      8'hFC: r=8'h77; 8'hFD: r=8'h6C; 8'hFE: r=8'hDA; 8'hFF: r=8'h1D;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte substitution of a whole word
  function automatic word_t hsub(input word_t w);
    return {hbox(w[31:24]), hbox(w[23:16]), hbox(w[15:8]), hbox(w[7:0])};
  endfunction

  function automatic word_t g5(input word_t w);
    word_t s;
    s = hsub(w);
    return {s[26:0], s[31:27]};
  endfunction

  function automatic word_t g13(input word_t w);
    word_t s;
    s = hsub(w);
    return {s[18:0], s[31:19]};
  endfunction

  function automatic word_t g21(input word_t w);
    word_t s;
    s = hsub(w);
    return {s[10:0], s[31:11]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/belt_round.sv
// ----------------------------------------------------------------------------
// belt_round
// One cipher round split over three register stages with a shared stall.
// ----------------------------------------------------------------------------
`default_nettype none
module belt_round #(
  parameter int unsigned RoundNum = 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   in_vld,
  input  wire belt_pkg::state_t in_st,
  input  wire belt_pkg::word_t  key_words [belt_pkg::NumKeyWords],
  output logic                  out_vld,
  output belt_pkg::state_t      out_st
);
  import belt_pkg::*;

  localparam int unsigned Base = 7 * (RoundNum - 1);
  localparam logic [2:0]  K0 = 3'((Base + 0) % NumKeyWords);
  localparam logic [2:0]  K1 = 3'((Base + 1) % NumKeyWords);
  localparam logic [2:0]  K2 = 3'((Base + 2) % NumKeyWords);
  localparam logic [2:0]  K3 = 3'((Base + 3) % NumKeyWords);
  localparam logic [2:0]  K4 = 3'((Base + 4) % NumKeyWords);
  localparam logic [2:0]  K5 = 3'((Base + 5) % NumKeyWords);
  localparam logic [2:0]  K6 = 3'((Base + 6) % NumKeyWords);
  localparam word_t       RoundW = 32'(RoundNum);

  state_t s1_nxt, s1_r, s2_nxt, s2_r, s3_nxt;
  logic   v1_r, v2_r, v3_r;
  word_t  e;

  // Step 1: b and c take G5/G21, then a drops by G13 of new b
  always_comb begin
    s1_nxt   = in_st;
    s1_nxt.b = in_st.b ^ g5(in_st.a + key_words[K0]);
    s1_nxt.c = in_st.c ^ g21(in_st.d + key_words[K1]);
    s1_nxt.a = in_st.a - g13(s1_nxt.b + key_words[K2]);
  end

  // Step 2: e mixing, then d grows by G13 of new c
  always_comb begin
    s2_nxt   = s1_r;
    e        = g21(s1_r.b + s1_r.c + key_words[K3]) ^ RoundW;
    s2_nxt.b = s1_r.b + e;
    s2_nxt.c = s1_r.c - e;
    s2_nxt.d = s1_r.d + g13(s2_nxt.c + key_words[K4]);
  end

  // Step 3: final XORs and word permutation
  always_comb begin
    word_t nb, nc;
    nb       = s2_r.b ^ g21(s2_r.a + key_words[K5]);
    nc       = s2_r.c ^ g5(s2_r.d + key_words[K6]);
    s3_nxt.a = nb;
    s3_nxt.b = s2_r.d;
    s3_nxt.c = s2_r.a;
    s3_nxt.d = nc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      out_st <= s3_nxt;
    end
  end

  assign out_vld = v3_r;

endmodule
`default_nettype wire

// File: rtl/belt_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// belt_block_encrypt_unit
// Fully pipelined block encryption, eight rounds of three stages each.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 256-bit key through cfg_we/cfg_idx/cfg_wdata while idle; four
//   64-bit registers each hold two key words (low word first).
//   Plaintext blocks enter on in_valid/in_ready, ciphertext leaves on
//   out_valid/out_ready, each transaction carrying one 128-bit block.
//   Each input block passes through three register stages per round, each
//   stage one chain of G evaluations with adds.
//   Throughput: one block per cycle unless stalled; the pipeline is 24 deep.
//   The whole pipeline advances together; when out_ready is low and the
//   last stage holds a block, every stage holds and in_ready drops.
//   Only a bubble in the last stage is squeezed out: a stall with an empty last stage still moves.
//   Reset clears valid bits and the key (all-zero key after reset).
// ----------------------------------------------------------------------------
`default_nettype none
`include "belt_block_encrypt_unit_macros.svh"
module belt_block_encrypt_unit (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire belt_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output belt_pkg::out_item_t     out_data,
  input  wire                     cfg_we,
  input  wire [belt_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire [belt_pkg::CfgDataW-1:0] cfg_wdata
);
  import belt_pkg::*;

  word_t  key_r [NumKeyWords];
  logic   adv;
  logic   vld   [NumRounds+1];
  state_t st    [NumRounds+1];

  // Key registers: every index of the two-bit field is a real register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumKeyWords; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      key_r[{cfg_idx, 1'b0}] <= cfg_wdata[31:0];
      key_r[{cfg_idx, 1'b1}] <= cfg_wdata[63:32];
    end
  end

  // Global advance: move unless the output holds an unaccepted block
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign vld[0]  = in_valid;
  assign st[0].a = in_data.plain_word_a;
  assign st[0].b = in_data.plain_word_b;
  assign st[0].c = in_data.plain_word_c;
  assign st[0].d = in_data.plain_word_d;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    belt_round #(.RoundNum(r + 1)) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld[r]),
      .in_st    (st[r]),
      .key_words(key_r),
      .out_vld  (vld[r+1]),
      .out_st   (st[r+1])
    );
  end

  assign out_valid              = vld[NumRounds];
  assign out_data.cipher_word_0 = st[NumRounds].b;
  assign out_data.cipher_word_1 = st[NumRounds].d;
  assign out_data.cipher_word_2 = st[NumRounds].a;
  assign out_data.cipher_word_3 = st[NumRounds].c;

  // Checks
  `BEU_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `BEU_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "not ready with empty output")
  `BEU_ASSERT_NORST(a_reset_clears, clk, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
`default_nettype wire

// File: tb/belt_block_encrypt_checker.sv
// ----------------------------------------------------------------------------
// belt_block_encrypt_checker
// Watches both channels and the key port, computes the expected ciphertext
// of each accepted block and compares it with what the unit returns.
// ----------------------------------------------------------------------------
module belt_block_encrypt_checker (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire                      in_ready,
  input  wire belt_pkg::in_item_t  in_data,
  input  wire                      out_valid,
  input  wire                      out_ready,
  input  wire belt_pkg::out_item_t out_data,
  input  wire                      cfg_we,
  input  wire [belt_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire [belt_pkg::CfgDataW-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending_blocks,
  output int                       blocks_checked
);
  import belt_pkg::*;

  // S-box of the cipher, kept independent of the package
  logic [7:0] sbox [256];
  logic [31:0] key_word [8];
  out_item_t cipher_queue [$];

  initial begin
    sbox = '{
      8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
      8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
      8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
      8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
      8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
      8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
      8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
      8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
      8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
      8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
      8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
      8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
      8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
      8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
      8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
      8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D};
  end

  // Substitute each byte, then rotate left
  function automatic logic [31:0] sub_rotate(input logic [31:0] w, input int rot);
    logic [31:0] s;
    logic [63:0] dbl;
    s = {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
    dbl = {s, s} << rot;
    return dbl[63:32];
  endfunction

  function automatic out_item_t encrypt_block(input in_item_t blk);
    logic [31:0] a, b, c, d, e, t;
    int base;
    out_item_t res;
    a = blk.plain_word_a; b = blk.plain_word_b;
    c = blk.plain_word_c; d = blk.plain_word_d;
    for (int rnd = 1; rnd <= 8; rnd++) begin
      base = 7 * rnd - 7;
      b = b ^ sub_rotate(a + key_word[base % 8], 5);
      c = c ^ sub_rotate(d + key_word[(base + 1) % 8], 21);
      a = a - sub_rotate(b + key_word[(base + 2) % 8], 13);
      e = sub_rotate(b + c + key_word[(base + 3) % 8], 21) ^ 32'(rnd);
      b = b + e;
      c = c - e;
      d = d + sub_rotate(c + key_word[(base + 4) % 8], 13);
      b = b ^ sub_rotate(a + key_word[(base + 5) % 8], 21);
      c = c ^ sub_rotate(d + key_word[(base + 6) % 8], 5);
      // net effect of the three swaps: a<-b, b<-d, c<-a, d<-c
      t = a; a = b; b = d; d = c; c = t;
    end
    res.cipher_word_0 = b;
    res.cipher_word_1 = d;
    res.cipher_word_2 = a;
    res.cipher_word_3 = c;
    return res;
  endfunction

  // Key tracking, prediction on input transactions, compare on output ones
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) key_word[k] = '0;
      cipher_queue.delete();
      fail_count <= 0;
      blocks_checked <= 0;
      pending_blocks <= 0;
    end else begin
      if (cfg_we && cfg_idx < NumCfgRegs) begin
        key_word[2 * cfg_idx]     = cfg_wdata[31:0];
        key_word[2 * cfg_idx + 1] = cfg_wdata[63:32];
      end
      if (in_valid && in_ready) cipher_queue.push_back(encrypt_block(in_data));
      if (out_valid && out_ready) begin
        blocks_checked <= blocks_checked + 1;
        if (cipher_queue.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_queue.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("ERROR: cipher mismatch exp %h %h %h %h got %h %h %h %h",
                       want.cipher_word_0, want.cipher_word_1, want.cipher_word_2,
                       want.cipher_word_3, out_data.cipher_word_0,
                       out_data.cipher_word_1, out_data.cipher_word_2,
                       out_data.cipher_word_3);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_blocks <= cipher_queue.size();
    end
  end
endmodule

// File: tb/tb_belt_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// tb_belt_block_encrypt_unit
// Drives plaintext blocks under several keys with bursty input and a stalling
// receiver; the checker predicts every ciphertext and counts mismatches.
// ----------------------------------------------------------------------------
module tb_belt_block_encrypt_unit;
  import belt_pkg::*;

  localparam int RandomBlocks = 500;
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int fail_count, pending_blocks, blocks_checked;
  int cycle_count = 0;
  int key_settings = 0;
  bit stall_mode = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  belt_block_encrypt_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_idx, .cfg_wdata
  );

  belt_block_encrypt_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending_blocks,
    .blocks_checked
  );

  // Receiver: alternates between ready streaks and random stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_mode) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= (cycle_count % 64) < 40 || $urandom_range(0, 1);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_belt_block_encrypt_unit failed");
      $finish;
    end
  end

  // Hand one block to the unit and wait for the transaction; valid stays up
  task automatic send_block(input in_item_t blk);
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (!in_ready);
  endtask

  // One key register write; the enable is dropped by the caller
  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    in_valid <= 1'b0;
    wait_drained();
    write_key(0, k0); write_key(1, k1); write_key(2, k2); write_key(3, k3);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Random blocks in bursts with idle gaps between them
  task automatic random_blocks(input int count);
    in_item_t blk;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        blk = {rand_word(), rand_word(), rand_word(), rand_word()};
        in_valid <= 1'b1;
        in_data  <= blk;
        do @(posedge clk); while (!in_ready);
      end
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    in_item_t blk;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero key from reset, extreme words
    send_block('0);
    send_block('1);
    send_block({32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0});
    send_block({32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'hFFFFFFFE});
    // Back-to-back single-bit blocks
    for (int k = 0; k < 8; k++) begin
      blk = '0;
      blk[k * 16 + 3] = 1'b1;
      send_block(blk);
    end
    load_key('1, '1, '1, '1);
    send_block('0);
    send_block('1);
    send_block({32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210});
    load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'h0, '1);
    send_block('0);
    send_block('1);
    send_block({32'hDEADBEEF, 32'hCAFEF00D, 32'h12345678, 32'h9ABCDEF0});

    // Random: key changes between phases, two phases with heavy stalls
    for (int phase = 0; phase < 5; phase++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      stall_mode = (phase % 2 == 1);
      random_blocks(RandomBlocks / 5);
      if (phase == 2) wait_drained();
    end
    load_key('0, '0, '0, '0);
    random_blocks(10);
    wait_drained();

    $display("Checked %0d blocks under %0d key settings, bursty input, stalled output.",
             blocks_checked, key_settings + 1);
    if (fail_count == 0) begin
      $display("tb_belt_block_encrypt_unit passed");
    end else begin
      $display("tb_belt_block_encrypt_unit failed");
    end
    $finish;
  end
endmodule
